### rtl/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the contiguous cluster allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

  // Command codes of an input beat
  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_ALLOC = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHIFT = 2'd0;
  localparam logic [1:0] CFG_DIR   = 2'd1;
  localparam logic [1:0] CFG_TOTAL = 2'd2;

  // Field widths
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned NEED_W  = SIZE_W + 1;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned DIR_W   = 11;
  localparam int unsigned TOTAL_W = 12;
  localparam int unsigned START_W = 11;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned CFGD_W  = 12;

  // Wide compare width for sums of cluster numbers and counts
  localparam int unsigned XW = NEED_W + 1;

  // Saturation of the reported run length
  localparam logic [LEN_W-1:0] LEN_SAT = 13'd4096;

  // Register reset values
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd10;
  localparam logic [DIR_W-1:0]   DIR_RST   = 11'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 12'd1440;

endpackage

`default_nettype wire

### rtl/cca_ram.sv
// ----------------------------------------------------------------------------
// cca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/contiguous_cluster_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_cluster_allocator
// First-fit allocator of contiguous cluster runs over a one-bit occupancy map.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i, file_size_i and first_cluster_i and raise start_i while
// busy_o is low; the command beat is taken at that edge. Exactly one result
// beat follows, shown for one cycle with done_o high on status_o, run_start_o
// and run_length_o. The receiver cannot stall; take the beat when done_o is
// high. Registers are written through cfg_valid_i/cfg_ready_o with
// cfg_index_i and cfg_data_i; cfg_ready_o is always high. The user must
// write them only while the block is idle; the block does not enforce it.
// The map lives in a 1-bit RAM with a registered read port, walked one
// cluster per cycle:
//   begin    : full rewrite of the map
//   mark     : a prep step, then one write per cluster inside the volume
//   allocate : read sweep over the volume, stops on first fit
//   unused   : no map access
// After reset, busy_o stays high while the map is cleared; no result beat
// is given for that pass. Registers take their reset values at once.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_cluster_allocator
  import cca_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 2048
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [SIZE_W-1:0]  file_size_i,
  input  wire logic [DIR_W-1:0]   first_cluster_i,
  // result channel
  output logic                    done_o,
  output logic                    status_o,
  output logic [START_W-1:0]      run_start_o,
  output logic [LEN_W-1:0]        run_length_o,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [CFGD_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_CLUSTERS);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_CLUSTERS - 1);
  localparam logic [XW-1:0] MAX_X    = XW'(MAX_CLUSTERS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_MARK_PREP,
    S_MARK,
    S_SCAN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [SHIFT_W-1:0] shift_q;
  logic [DIR_W-1:0]   dir_q;
  logic [TOTAL_W-1:0] total_q;

  // work registers
  logic [CW-1:0]      idx_q;
  logic [CW-1:0]      stop_q;
  logic [NEED_W-1:0]  need_q;
  logic [DIR_W-1:0]   first_q;
  logic               fill_set_q;
  logic [CW-1:0]      cnt_q;
  logic [AW-1:0]      cand_q;
  logic               pend_q;
  logic [AW-1:0]      pend_idx_q;

  // result registers
  logic               busy_q;
  logic               done_q;
  logic               status_q;
  logic [START_W-1:0] start_q;
  logic [LEN_W-1:0]   len_q;

  // RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic          rd_en;
  logic          rd_data;

  // volume size, min(total, MAX_CLUSTERS)
  logic [XW-1:0] total_x;
  logic [XW-1:0] vol_x;
  logic [XW-1:0] idx_x;
  logic [CW-1:0] vol;

  // command decode helpers
  logic              accept;
  logic [NEED_W-1:0] need_new;
  logic [LEN_W-1:0]  len_new;
  logic [XW-1:0]     sum_x;
  logic [XW-1:0]     stop_x;
  logic [XW-1:0]     first_x;

  // scan helpers
  logic          hit;
  logic [CW-1:0] cnt_inc;
  logic          found;
  logic [AW-1:0] found_start;
  logic [XW-1:0] found_start_x;

  assign total_x = XW'(total_q);
  assign vol_x   = (total_x < MAX_X) ? total_x : MAX_X;
  assign vol     = vol_x[CW-1:0];
  assign idx_x   = XW'(idx_q);

  assign accept   = start_i && !busy_q;
  assign need_new = NEED_W'(file_size_i >> shift_q) + NEED_W'(1);
  assign len_new  = (need_new > NEED_W'(LEN_SAT)) ? LEN_SAT : need_new[LEN_W-1:0];

  // extent end of a mark, clamped to the volume
  assign first_x = XW'(first_q);
  assign sum_x   = first_x + XW'(need_q);
  assign stop_x  = (sum_x > vol_x) ? vol_x : sum_x;

  // first-fit run tracking on the data coming back from the RAM
  assign hit           = pend_q && !rd_data;
  assign cnt_inc       = cnt_q + CW'(1);
  assign found         = hit && (XW'(cnt_inc) >= XW'(need_q));
  assign found_start   = (cnt_q == '0) ? pend_idx_q : cand_q;
  assign found_start_x = XW'(found_start);

  // RAM access per state
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = 1'b0;
    rd_en   = 1'b0;
    unique case (state_q)
      S_FILL: begin
        wr_en   = 1'b1;
        wr_data = fill_set_q && (idx_x <= XW'(dir_q)) && (idx_x < vol_x);
      end
      S_MARK: begin
        wr_en   = 1'b1;
        wr_data = 1'b1;
      end
      S_SCAN: begin
        rd_en = (idx_q < vol) && !found;
      end
      default: begin
      end
    endcase
  end

  cca_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CLUSTERS)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RST;
      dir_q   <= DIR_RST;
      total_q <= TOTAL_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SHIFT) shift_q <= cfg_data_i[SHIFT_W-1:0];
      if (cfg_index_i == CFG_DIR)   dir_q   <= cfg_data_i[DIR_W-1:0];
      if (cfg_index_i == CFG_TOTAL) total_q <= cfg_data_i[TOTAL_W-1:0];
    end
  end

  // control state machine and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_FILL;
      busy_q     <= 1'b1;
      done_q     <= 1'b0;
      fill_set_q <= 1'b0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      cnt_q      <= '0;
      stop_q     <= '0;
      need_q     <= '0;
      first_q    <= '0;
      cand_q     <= '0;
      pend_idx_q <= '0;
      status_q   <= 1'b0;
      start_q    <= '0;
      len_q      <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= 1'b0;
            start_q  <= '0;
            need_q   <= need_new;
            first_q  <= first_cluster_i;
            idx_q    <= '0;
            cnt_q    <= '0;
            pend_q   <= 1'b0;
            unique case (cmd_e'(cmd_i))
              CMD_BEGIN: begin
                len_q      <= LEN_W'(dir_q) + LEN_W'(1);
                fill_set_q <= 1'b1;
                state_q    <= S_FILL;
                busy_q     <= 1'b1;
              end
              CMD_MARK: begin
                len_q   <= len_new;
                state_q <= S_MARK_PREP;
                busy_q  <= 1'b1;
              end
              CMD_ALLOC: begin
                len_q   <= len_new;
                state_q <= S_SCAN;
                busy_q  <= 1'b1;
              end
              default: begin
                // unused command: no change, all-zero result
                len_q  <= '0;
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_FILL: begin
          idx_q <= idx_q + CW'(1);
          if (idx_q == LAST_IDX) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= fill_set_q;
          end
        end
        S_MARK_PREP: begin
          if (first_x >= stop_x) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end else begin
            idx_q   <= first_x[CW-1:0];
            stop_q  <= stop_x[CW-1:0];
            state_q <= S_MARK;
          end
        end
        S_MARK: begin
          idx_q <= idx_q + CW'(1);
          if (idx_q + CW'(1) == stop_q) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        S_SCAN: begin
          pend_q     <= rd_en;
          pend_idx_q <= idx_q[AW-1:0];
          if (rd_en) idx_q <= idx_q + CW'(1);
          if (pend_q) begin
            if (rd_data) begin
              cnt_q <= '0;
            end else begin
              if (cnt_q == '0) cand_q <= pend_idx_q;
              cnt_q <= cnt_inc;
            end
          end
          priority if (found) begin
            start_q <= found_start_x[START_W-1:0];
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end else if (!pend_q && !rd_en) begin
            status_q <= 1'b1;
            state_q  <= S_IDLE;
            busy_q   <= 1'b0;
            done_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign cfg_ready_o  = 1'b1;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign run_start_o  = start_q;
  assign run_length_o = len_q;

`ifndef NO_ASSERTIONS
  // a result beat only appears as the block goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result beat while busy");

  // a failed search reports start zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (run_start_o == '0))
    else $error("failed search with nonzero start");

  // the map is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en && rd_en))
    else $error("map read and write overlap");

  // returned data is only consumed for a read issued the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> $past(rd_en))
    else $error("map data consumed without a read");
`endif

endmodule

`default_nettype wire
